// ===== sv/cflts_pkg.sv =====
`default_nettype none

package cflts_pkg;

   // Fixed-point defaults
   localparam int FRAC_BITS_DEF    = 16;
   localparam int TIME_EPSILON_DEF = 1;

   // Field widths
   localparam int WORD_W  = 32;
   localparam int TOTAL_W = 48;

   // CSR port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_CFL_LIMIT    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_STEP_MIN     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_STEP_MAX     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_LENGTH = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_ADAPTIVE     = 3'd4;

   // Commands
   localparam logic CMD_ADAPT = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Current register values, the mode bit being written and the mode-write strobe
   typedef struct packed {
      logic [WORD_W-1:0] cfl_limit;
      logic [WORD_W-1:0] step_min;
      logic [WORD_W-1:0] step_max;
      logic [WORD_W-1:0] frame_length;
      logic              adaptive_mode;
      logic              mode_write;
   } cfg_type;

endpackage

`default_nettype wire

// ===== sv/cflts_csr.sv =====
`default_nettype none

module cflts_csr #(
   parameter int FRAC_BITS = cflts_pkg::FRAC_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire [cflts_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire [cflts_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [cflts_pkg::CSR_DATA_W-1:0] prdata,
   output cflts_pkg::cfg_type               cfg
);

   localparam logic [cflts_pkg::WORD_W-1:0] ONE_UNIT =
      cflts_pkg::WORD_W'(1) << FRAC_BITS;
   localparam logic [cflts_pkg::WORD_W-1:0] CFL_RESET =
      cflts_pkg::WORD_W'(1000) << FRAC_BITS;

   logic [cflts_pkg::WORD_W-1:0]    cfl_limit_ff;
   logic [cflts_pkg::WORD_W-1:0]    step_min_ff;
   logic [cflts_pkg::WORD_W-1:0]    step_max_ff;
   logic [cflts_pkg::WORD_W-1:0]    frame_length_ff;
   logic                            adaptive_ff;
   logic                            wr_en;
   logic [cflts_pkg::REG_IDX_W-1:0] idx;

   assign wr_en = psel & penable & pwrite;
   assign idx   = paddr[cflts_pkg::CSR_ADDR_W-1:2];

   // Register writes, out-of-range indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfl_limit_ff    <= CFL_RESET;
         step_min_ff     <= ONE_UNIT;
         step_max_ff     <= ONE_UNIT;
         frame_length_ff <= ONE_UNIT;
         adaptive_ff     <= 1'b1;
      end else if (wr_en) begin
         unique case (idx)
            cflts_pkg::REG_CFL_LIMIT:    cfl_limit_ff    <= pwdata;
            cflts_pkg::REG_STEP_MIN:     step_min_ff     <= pwdata;
            cflts_pkg::REG_STEP_MAX:     step_max_ff     <= pwdata;
            cflts_pkg::REG_FRAME_LENGTH: frame_length_ff <= pwdata;
            cflts_pkg::REG_ADAPTIVE:     adaptive_ff     <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      unique case (idx)
         cflts_pkg::REG_CFL_LIMIT:    prdata = cfl_limit_ff;
         cflts_pkg::REG_STEP_MIN:     prdata = step_min_ff;
         cflts_pkg::REG_STEP_MAX:     prdata = step_max_ff;
         cflts_pkg::REG_FRAME_LENGTH: prdata = frame_length_ff;
         cflts_pkg::REG_ADAPTIVE:     prdata = {{(cflts_pkg::CSR_DATA_W-1){1'b0}}, adaptive_ff};
         default:                     prdata = '0;
      endcase
   end

   always_comb begin
      cfg.cfl_limit     = cfl_limit_ff;
      cfg.step_min      = step_min_ff;
      cfg.step_max      = step_max_ff;
      cfg.frame_length  = frame_length_ff;
      cfg.adaptive_mode = pwdata[0];
      cfg.mode_write    = wr_en && (idx == cflts_pkg::REG_ADAPTIVE);
   end

endmodule

`default_nettype wire

// ===== sv/cflts_divider.sv =====
`default_nettype none

// Restoring radix-2 divider, one quotient bit per cycle
module cflts_divider #(
   parameter int DIVIDEND_W = 48,
   parameter int DIVISOR_W  = 33
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  wire [DIVIDEND_W-1:0]  dividend,
   input  wire [DIVISOR_W-1:0]   divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  div_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign fits    = !diff[DIVISOR_W];

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIVIDEND_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: shift in dividend bits, subtract when the divisor fits
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== sv/cfl_adaptive_timestep.sv =====
`default_nettype none

// Channel   Direction  Handshake                      Payload
// req       in         req_valid / req_ready          req_command, req_max_velocity
// rsp       out        rsp_valid / rsp_ready          step, frame time, frame, total, flags
// csr       in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// An adapt waits in S_DIV for the bit-serial divider, then passes S_CLAMP, S_COMPARE,
// S_FIT and S_CHECK; a locked adapt goes straight to S_CHECK. A step passes S_STEP,
// and on a frame wrap S_PRODUCT and S_TOTAL (frame count times frame length, saturated).
// One item is in flight at a time; req_ready is high only when idle.
// A finished result waits in the output register; the block stays in its
// done state until that register is free. Reset is synchronous.
module cfl_adaptive_timestep #(
   parameter int FRAC_BITS    = cflts_pkg::FRAC_BITS_DEF,
   parameter int TIME_EPSILON = cflts_pkg::TIME_EPSILON_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire                                req_command,
   input  wire [cflts_pkg::WORD_W-1:0]        req_max_velocity,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [cflts_pkg::WORD_W-1:0]       rsp_step_size,
   output logic [cflts_pkg::WORD_W-1:0]       rsp_time_in_frame,
   output logic [cflts_pkg::WORD_W-1:0]       rsp_frame_index,
   output logic [cflts_pkg::TOTAL_W-1:0]      rsp_total_time,
   output logic                               rsp_step_locked,
   output logic                               rsp_step_invalid,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire [cflts_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire [cflts_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [cflts_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready
);

   localparam int W   = cflts_pkg::WORD_W;
   localparam int TW  = cflts_pkg::TOTAL_W;
   localparam int DVD = W + FRAC_BITS;
   localparam int DVS = W + 1;
   localparam logic [W-1:0]  ONE_UNIT = W'(1) << FRAC_BITS;
   localparam logic [W-1:0]  MAX32    = {W{1'b1}};
   localparam logic [TW-1:0] MAX48    = {TW{1'b1}};
   localparam int NEAR_EPS_I = ((1 << FRAC_BITS) + 5000) / 10000;
   localparam logic [W:0]    NEAR_EPS = (W+1)'(NEAR_EPS_I);
   localparam logic [W+1:0]  EPS_W    = (W+2)'(TIME_EPSILON);

   // Sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DIV     = 4'd1;
   localparam logic [3:0] S_CLAMP   = 4'd2;
   localparam logic [3:0] S_COMPARE = 4'd3;
   localparam logic [3:0] S_FIT     = 4'd4;
   localparam logic [3:0] S_CHECK   = 4'd5;
   localparam logic [3:0] S_STEP    = 4'd6;
   localparam logic [3:0] S_PRODUCT = 4'd7;
   localparam logic [3:0] S_TOTAL   = 4'd8;
   localparam logic [3:0] S_DONE    = 4'd9;

   cflts_pkg::cfg_type cfg;

   logic [3:0]      state_ff, state_in;
   logic [W-1:0]    step_ff, step_in;
   logic [W-1:0]    ftime_ff, ftime_in;
   logic [W-1:0]    fcount_ff, fcount_in;
   logic [TW-1:0]   total_ff, total_in;
   logic            lock_ff, lock_in;
   logic            adapted_ff, adapted_in;
   logic            rsp_valid_ff;

   // Per-item working registers
   logic            div_zero_ff;
   logic [W-1:0]    quot_ff;
   logic [W-1:0]    dt_ff;
   logic            near_ff;
   logic            split_ff;
   logic            invalid_ff;
   logic [2*W-1:0]  prod_ff;

   logic            in_xfer;
   logic            out_load;
   logic            div_start;
   logic            div_done;
   logic [DVD-1:0]  div_quot;
   logic [DVS-1:0]  divisor;

   // Combinational helpers
   logic [W-1:0]    quot_sat;
   logic [W-1:0]    clamped;
   logic [W+7:0]    lhs100, rhs100;
   logic [W+3:0]    lhs4, rhs4;
   logic [W+1:0]    sum3;
   logic [W-1:0]    rest;
   logic [W:0]      rest_eps;
   logic [W:0]      ft_sum;
   logic [W-1:0]    ft_new;
   logic [W+1:0]    ft_eps;
   logic [TW:0]     tot_sum;
   logic [W:0]      fc_inc;

   cflts_csr #(
      .FRAC_BITS (FRAC_BITS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   assign csr_pready = 1'b1;

   assign divisor   = {1'b0, req_max_velocity} + DVS'(TIME_EPSILON);
   assign div_start = in_xfer && (req_command == cflts_pkg::CMD_ADAPT) && !lock_ff;

   cflts_divider #(
      .DIVIDEND_W (DVD),
      .DIVISOR_W  (DVS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({cfg.cfl_limit, {FRAC_BITS{1'b0}}}),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign in_xfer   = req_valid && req_ready;
   assign out_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   // Datapath terms
   always_comb begin
      quot_sat = (|div_quot[DVD-1:W]) ? MAX32 : div_quot[W-1:0];
      clamped  = (quot_ff > cfg.step_max) ? cfg.step_max : quot_ff;
      if (clamped < cfg.step_min) begin
         clamped = cfg.step_min;
      end
      lhs100   = (W+8)'(ftime_ff) * (W+8)'(100) + (W+8)'(dt_ff) * (W+8)'(105);
      rhs100   = (W+8)'(cfg.frame_length) * (W+8)'(100);
      lhs4     = ((W+4)'(ftime_ff) << 2) + (W+4)'(dt_ff) * (W+4)'(5);
      rhs4     = (W+4)'(cfg.frame_length) << 2;
      sum3     = (W+2)'(ftime_ff) + (W+2)'(dt_ff) + (W+2)'(cfg.step_min);
      rest     = (cfg.frame_length > ftime_ff) ? (cfg.frame_length - ftime_ff) : '0;
      rest_eps = {1'b0, rest} + NEAR_EPS;
      ft_sum   = {1'b0, ftime_ff} + {1'b0, step_ff};
      ft_new   = ft_sum[W] ? MAX32 : ft_sum[W-1:0];
      ft_eps   = (W+2)'(ft_new) + EPS_W;
      tot_sum  = {1'b0, total_ff} + (TW+1)'(step_ff);
      fc_inc   = {1'b0, fcount_ff} + (W+1)'(1);
   end

   // Sequencer and state update
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      ftime_in   = ftime_ff;
      fcount_in  = fcount_ff;
      total_in   = total_ff;
      lock_in    = lock_ff;
      adapted_in = adapted_ff;
      if (cfg.mode_write) begin
         adapted_in = cfg.adaptive_mode;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (in_xfer) begin
               if (req_command == cflts_pkg::CMD_STEP) begin
                  state_in = S_STEP;
               end else if (lock_ff) begin
                  state_in = S_CHECK;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_CLAMP;
            end
         end
         S_CLAMP:   state_in = S_COMPARE;
         S_COMPARE: state_in = S_FIT;
         S_FIT: begin
            priority if (near_ff) begin
               step_in = rest_eps[W] ? MAX32 : rest_eps[W-1:0];
            end else if (split_ff) begin
               step_in = rest_eps[W:1];
               lock_in = 1'b1;
            end else begin
               step_in = dt_ff;
            end
            state_in = S_CHECK;
         end
         S_CHECK: begin
            adapted_in = 1'b1;
            state_in   = S_DONE;
         end
         S_STEP: begin
            if (!adapted_ff) begin
               total_in  = tot_sum[TW] ? MAX48 : tot_sum[TW-1:0];
               fcount_in = fc_inc[W] ? MAX32 : fc_inc[W-1:0];
               state_in  = S_DONE;
            end else if (ft_eps > (W+2)'(cfg.frame_length)) begin
               fcount_in = fc_inc[W] ? MAX32 : fc_inc[W-1:0];
               ftime_in  = '0;
               lock_in   = 1'b0;
               state_in  = S_PRODUCT;
            end else begin
               ftime_in = ft_new;
               state_in = S_DONE;
            end
         end
         S_PRODUCT: state_in = S_TOTAL;
         S_TOTAL: begin
            total_in = (|prod_ff[2*W-1:TW]) ? MAX48 : prod_ff[TW-1:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= ONE_UNIT;
         ftime_ff     <= '0;
         fcount_ff    <= '0;
         total_ff     <= '0;
         lock_ff      <= 1'b0;
         adapted_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         ftime_ff   <= ftime_in;
         fcount_ff  <= fcount_in;
         total_ff   <= total_in;
         lock_ff    <= lock_in;
         adapted_ff <= adapted_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (in_xfer) begin
         div_zero_ff <= (divisor == '0);
         invalid_ff  <= 1'b0;
      end
      if (state_ff == S_DIV && div_done) begin
         quot_ff <= div_zero_ff ? MAX32 : quot_sat;
      end
      if (state_ff == S_CLAMP) begin
         dt_ff <= clamped;
      end
      if (state_ff == S_COMPARE) begin
         near_ff  <= lhs100 > rhs100;
         split_ff <= (sum3 > (W+2)'(cfg.frame_length)) || (lhs4 > rhs4);
      end
      if (state_ff == S_CHECK) begin
         invalid_ff <= !({step_ff, 1'b0} > {1'b0, cfg.step_min});
      end
      if (state_ff == S_PRODUCT) begin
         prod_ff <= (2*W)'(fcount_ff) * (2*W)'(cfg.frame_length);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_step_size     <= step_ff;
         rsp_time_in_frame <= ftime_ff;
         rsp_frame_index   <= fcount_ff;
         rsp_total_time    <= total_ff;
         rsp_step_locked   <= lock_ff;
         rsp_step_invalid  <= invalid_ff;
      end
   end

endmodule

`default_nettype wire
